[rtl/mrd_pkg.sv]
// mrd_pkg: shared types and codes for the measurement record deframer
// no dependencies
`default_nettype none
package mrd_pkg;

    // operation codes of an input transfer
    localparam logic OP_STREAM = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // register indexes
    localparam logic CFG_ID_BYTES   = 1'b0;
    localparam logic CFG_BYTE_LIMIT = 1'b1;

    // result status codes
    localparam logic [2:0] ST_PAYLOAD   = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_UNKNOWN   = 3'd2;
    localparam logic [2:0] ST_BAD_WIDTH = 3'd3;
    localparam logic [2:0] ST_PAST_END  = 3'd4;

    typedef enum logic [1:0] {
        PH_ID,
        PH_LEN,
        PH_BODY
    } phase_t;

    // group attributes as read from the slot table
    typedef struct packed {
        logic        vlsd;
        logic        subscribed;
        logic [31:0] size;
        logic [31:0] limit;
        logic [31:0] count;
    } slot_attr_t;

    // group table load
    typedef struct packed {
        logic        en;
        logic [2:0]  index;
        logic [63:0] rec_key;
        logic [31:0] size;
        logic        vlsd;
        logic        subscribed;
        logic [31:0] limit;
        logic        valid;
    } slot_load_t;

endpackage
`default_nettype wire

[rtl/mrd_slot_table.sv]
// mrd_slot_table: group table with id match, attribute read and sample counters
// depends on mrd_pkg
`default_nettype none
module mrd_slot_table #(
    parameter int GROUP_SLOTS = 8,
    parameter int GW = 3
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  mrd_pkg::slot_load_t     load,
    input  wire [63:0]              match_id,
    output logic                    hit,
    output logic [GW-1:0]           hit_index,
    output logic                    slot0_valid,
    output logic [63:0]             slot0_id,
    input  wire [GW-1:0]            rd_index,
    output mrd_pkg::slot_attr_t     rd_attr,
    input  wire                     inc_en,
    input  wire [GW-1:0]            inc_index
);
    import mrd_pkg::*;

    logic [GROUP_SLOTS-1:0] valid_reg;
    logic [63:0]            id_reg    [GROUP_SLOTS];
    logic [31:0]            size_reg  [GROUP_SLOTS];
    logic                   vlsd_reg  [GROUP_SLOTS];
    logic                   sub_reg   [GROUP_SLOTS];
    logic [31:0]            limit_reg [GROUP_SLOTS];
    logic [31:0]            count_reg [GROUP_SLOTS];
    logic                   load_hit;
    logic [GW-1:0]          load_slot;

    assign load_hit  = load.en && (7'(load.index) < 7'(GROUP_SLOTS));
    assign load_slot = GW'(load.index);

    // valid bits and sample counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < GROUP_SLOTS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (load_hit)
        begin
            valid_reg[load_slot] <= load.valid;
            count_reg[load_slot] <= '0;
        end
        else if (inc_en && (count_reg[inc_index] < limit_reg[inc_index]))
        begin
            count_reg[inc_index] <= count_reg[inc_index] + 32'd1;
        end
    end

    // slot contents
    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            id_reg[load_slot]    <= load.rec_key;
            size_reg[load_slot]  <= load.size;
            vlsd_reg[load_slot]  <= load.vlsd;
            sub_reg[load_slot]   <= load.subscribed;
            limit_reg[load_slot] <= load.limit;
        end
    end

    // parallel id compare, lowest slot wins
    always_comb
    begin
        hit       = 1'b0;
        hit_index = '0;
        for (int i = GROUP_SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && id_reg[i] == match_id)
            begin
                hit       = 1'b1;
                hit_index = GW'(i);
            end
        end
    end

    assign slot0_valid = valid_reg[0];
    assign slot0_id    = id_reg[0];

    always_comb
    begin
        rd_attr.vlsd       = vlsd_reg[rd_index];
        rd_attr.subscribed = sub_reg[rd_index];
        rd_attr.size       = size_reg[rd_index];
        rd_attr.limit      = limit_reg[rd_index];
        rd_attr.count      = count_reg[rd_index];
    end

endmodule
`default_nettype wire

[rtl/measurement_record_deframer.sv]
// measurement_record_deframer: byte-serial record parser, top level
// depends on mrd_pkg and mrd_slot_table
`default_nettype none
// Takes one stream byte or one group table load per cycle; every transfer
// gives at most one result, registered at the output, so the block sustains
// one item per clock while the output is taken. The id compare over all
// slots runs in parallel in the cycle of the last id byte. After an error
// result (unknown id, bad id width, past byte limit) stream bytes are
// ignored until reset; loads are still taken. No clearing pass after reset.
module measurement_record_deframer #(
    parameter int GROUP_SLOTS = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire [47:0]  cfg_data,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         operation,
    input  wire [7:0]   data_byte,
    input  wire [2:0]   entry_index,
    input  wire [63:0]  entry_record_id,
    input  wire [31:0]  entry_record_bytes,
    input  wire         entry_is_vlsd,
    input  wire         entry_subscribed,
    input  wire [31:0]  entry_sample_limit,
    input  wire         entry_valid,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [2:0]  status,
    output logic [2:0]  group_index,
    output logic [63:0] frame_id,
    output logic [31:0] sample_index,
    output logic [7:0]  payload_byte,
    output logic        last_in_record
);
    import mrd_pkg::*;

    localparam int GW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;

    logic [3:0]    id_bytes_reg;
    logic [47:0]   byte_limit_reg;
    phase_t        phase_reg, phase_next;
    logic [63:0]   id_reg, id_next;
    logic [3:0]    hbc_reg, hbc_next;
    logic [31:0]   len_reg, len_next;
    logic [31:0]   left_reg, left_next;
    logic [GW-1:0] grp_reg, grp_next;
    logic          emits_reg, emits_next;
    logic [47:0]   consumed_reg, consumed_next;
    logic          halted_reg, halted_next;
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    status_reg, status_next;
    logic [2:0]    group_reg, group_next;
    logic [63:0]   rid_reg, rid_next;
    logic [31:0]   smp_reg, smp_next;
    logic [7:0]    pay_reg, pay_next;
    logic          last_reg, last_next;

    slot_load_t    load;
    slot_attr_t    attr;
    logic          hit;
    logic [GW-1:0] hit_index;
    logic          slot0_valid;
    logic [63:0]   slot0_id;
    logic [63:0]   id_full;
    logic [GW-1:0] grp_sel;
    logic          inc_en;
    logic          in_fire;
    logic          id_width_ok;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign id_width_ok = (id_bytes_reg == 4'd0) || (id_bytes_reg == 4'd1) ||
                         (id_bytes_reg == 4'd2) || (id_bytes_reg == 4'd4) ||
                         (id_bytes_reg == 4'd8);

    // table load from the input transfer
    always_comb
    begin
        load.en         = in_fire && (operation == OP_LOAD);
        load.index      = entry_index;
        load.rec_key    = entry_record_id;
        load.size       = entry_record_bytes;
        load.vlsd       = entry_is_vlsd;
        load.subscribed = entry_subscribed;
        load.limit      = entry_sample_limit;
        load.valid      = entry_valid;
    end

    // id with the arriving byte merged in, and the group this byte works on
    assign id_full = id_reg | (64'(data_byte) << {hbc_reg[2:0], 3'b000});

    always_comb
    begin
        if (phase_reg != PH_ID)
        begin
            grp_sel = grp_reg;
        end
        else if (id_bytes_reg == 4'd0)
        begin
            grp_sel = '0;
        end
        else
        begin
            grp_sel = hit_index;
        end
    end

    mrd_slot_table #(
        .GROUP_SLOTS (GROUP_SLOTS),
        .GW          (GW)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .match_id    (id_full),
        .hit         (hit),
        .hit_index   (hit_index),
        .slot0_valid (slot0_valid),
        .slot0_id    (slot0_id),
        .rd_index    (grp_sel),
        .rd_attr     (attr),
        .inc_en      (inc_en),
        .inc_index   (grp_sel)
    );

    // parse step for one stream byte
    always_comb
    begin
        logic        do_len;
        logic        do_body;
        logic        do_start;
        logic        do_end;
        logic [31:0] start_n;
        logic        fail;
        logic [2:0]  fail_st;
        logic [63:0] fail_id;

        do_len   = 1'b0;
        do_body  = 1'b0;
        do_start = 1'b0;
        do_end   = 1'b0;
        start_n  = '0;
        fail     = 1'b0;
        fail_st  = ST_PAYLOAD;
        fail_id  = '0;

        phase_next    = phase_reg;
        id_next       = id_reg;
        hbc_next      = hbc_reg;
        len_next      = len_reg;
        left_next     = left_reg;
        grp_next      = grp_reg;
        emits_next    = emits_reg;
        consumed_next = consumed_reg;
        halted_next   = halted_reg;
        inc_en        = 1'b0;

        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        group_next     = group_reg;
        rid_next       = rid_reg;
        smp_next       = smp_reg;
        pay_next       = pay_reg;
        last_next      = last_reg;

        if (in_fire && operation == OP_STREAM && !halted_reg)
        begin
            if (consumed_reg >= byte_limit_reg)
            begin
                fail    = 1'b1;
                fail_st = ST_PAST_END;
            end
            else
            begin
                consumed_next = consumed_reg + 48'd1;
                unique case (phase_reg)
                    PH_ID:
                    begin
                        if (!id_width_ok)
                        begin
                            fail    = 1'b1;
                            fail_st = ST_BAD_WIDTH;
                        end
                        else if (id_bytes_reg == 4'd0)
                        begin
                            if (!slot0_valid)
                            begin
                                fail    = 1'b1;
                                fail_st = ST_UNKNOWN;
                            end
                            else
                            begin
                                grp_next = '0;
                                id_next  = slot0_id;
                                if (attr.vlsd)
                                begin
                                    do_len = 1'b1;
                                end
                                else
                                begin
                                    do_start = 1'b1;
                                    start_n  = attr.size;
                                    do_body  = (attr.size != 32'd0);
                                end
                            end
                        end
                        else
                        begin
                            id_next  = id_full;
                            hbc_next = hbc_reg + 4'd1;
                            if (hbc_next >= id_bytes_reg)
                            begin
                                hbc_next = '0;
                                if (!hit)
                                begin
                                    fail    = 1'b1;
                                    fail_st = ST_UNKNOWN;
                                    fail_id = id_full;
                                end
                                else
                                begin
                                    grp_next = hit_index;
                                    if (attr.vlsd)
                                    begin
                                        phase_next = PH_LEN;
                                        len_next   = '0;
                                    end
                                    else
                                    begin
                                        do_start = 1'b1;
                                        start_n  = attr.size;
                                    end
                                end
                            end
                        end
                    end
                    PH_LEN:
                    begin
                        do_len = 1'b1;
                    end
                    default:
                    begin
                        do_body = 1'b1;
                    end
                endcase

                // length prefix byte; zero-width id starts from a clean count
                if (do_len)
                begin
                    logic [1:0]  pos;
                    logic [31:0] lv;
                    pos = (phase_reg == PH_LEN) ? hbc_reg[1:0] : 2'd0;
                    lv  = (phase_reg == PH_LEN) ? len_reg : 32'd0;
                    lv  = lv | (32'(data_byte) << {pos, 3'b000});
                    phase_next = PH_LEN;
                    len_next   = lv;
                    hbc_next   = 4'(pos) + 4'd1;
                    if (pos == 2'd3)
                    begin
                        hbc_next = '0;
                        do_start = 1'b1;
                        start_n  = lv;
                    end
                end

                // record body start
                if (do_start)
                begin
                    emits_next = attr.subscribed && (attr.count < attr.limit);
                    if (start_n == 32'd0)
                    begin
                        if (emits_next)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = ST_EMPTY;
                            group_next     = 3'(grp_sel);
                            rid_next       = id_next;
                            smp_next       = attr.count;
                            pay_next       = '0;
                            last_next      = 1'b1;
                        end
                        do_end = 1'b1;
                    end
                    else
                    begin
                        left_next  = start_n;
                        phase_next = PH_BODY;
                    end
                end

                // payload byte
                if (do_body)
                begin
                    if (emits_next)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_PAYLOAD;
                        group_next     = 3'(grp_sel);
                        rid_next       = id_next;
                        smp_next       = attr.count;
                        pay_next       = data_byte;
                        last_next      = (left_next == 32'd1);
                    end
                    if (left_next != 32'd0)
                    begin
                        left_next = left_next - 32'd1;
                    end
                    if (left_next == 32'd0)
                    begin
                        do_end = 1'b1;
                    end
                end

                // record end
                if (do_end)
                begin
                    inc_en     = 1'b1;
                    phase_next = PH_ID;
                    hbc_next   = '0;
                    len_next   = '0;
                    left_next  = '0;
                    id_next    = '0;
                end
            end

            if (fail)
            begin
                halted_next    = 1'b1;
                inc_en         = 1'b0;
                out_valid_next = 1'b1;
                status_next    = fail_st;
                group_next     = '0;
                rid_next       = fail_id;
                smp_next       = '0;
                pay_next       = '0;
                last_next      = 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_bytes_reg   <= '0;
            byte_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ID_BYTES:   id_bytes_reg   <= cfg_data[3:0];
                CFG_BYTE_LIMIT: byte_limit_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ID;
            id_reg        <= '0;
            hbc_reg       <= '0;
            len_reg       <= '0;
            left_reg      <= '0;
            grp_reg       <= '0;
            emits_reg     <= 1'b0;
            consumed_reg  <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            id_reg        <= id_next;
            hbc_reg       <= hbc_next;
            len_reg       <= len_next;
            left_reg      <= left_next;
            grp_reg       <= grp_next;
            emits_reg     <= emits_next;
            consumed_reg  <= consumed_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        group_reg  <= group_next;
        rid_reg    <= rid_next;
        smp_reg    <= smp_next;
        pay_reg    <= pay_next;
        last_reg   <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign group_index    = group_reg;
    assign frame_id       = rid_reg;
    assign sample_index   = smp_reg;
    assign payload_byte   = pay_reg;
    assign last_in_record = last_reg;

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    // an error result always comes with the halt flag
    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_UNKNOWN || status_reg == ST_BAD_WIDTH ||
         status_reg == ST_PAST_END)) |-> halted_reg)
        else $error("error result without halt");

    // body phase always has bytes left
    a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (left_reg != 32'd0))
        else $error("body phase with no bytes left");

endmodule
`default_nettype wire

[dv/mrd_check.sv]
// mrd_check: watches the deframer channels, predicts every result and compares
// depends on mrd_pkg for codes and the parse phase type
`default_nettype none
module mrd_check (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire [47:0]  cfg_data,
    input  wire         in_valid,
    input  wire         in_ready,
    input  wire         operation,
    input  wire [7:0]   data_byte,
    input  wire [2:0]   entry_index,
    input  wire [63:0]  entry_record_id,
    input  wire [31:0]  entry_record_bytes,
    input  wire         entry_is_vlsd,
    input  wire         entry_subscribed,
    input  wire [31:0]  entry_sample_limit,
    input  wire         entry_valid,
    input  wire         out_valid,
    input  wire         out_ready,
    input  wire [2:0]   status,
    input  wire [2:0]   group_index,
    input  wire [63:0]  frame_id,
    input  wire [31:0]  sample_index,
    input  wire [7:0]   payload_byte,
    input  wire         last_in_record,
    output int          err_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mrd_pkg::*;

    typedef struct {
        logic [2:0]  st;
        logic [2:0]  grp;
        logic [63:0] id;
        logic [31:0] smp;
        logic [7:0]  pb;
        logic        last;
    } frame_out_t;

    frame_out_t deframed_q[$];

    // own copy of registers and parser state
    logic [3:0]  id_width;
    logic [47:0] byte_limit;
    phase_t      phase;
    logic [63:0] acc_id;
    logic [3:0]  hdr_cnt;
    logic [31:0] len_acc;
    logic [31:0] left;
    logic [2:0]  grp;
    logic        emits;
    logic [47:0] consumed;
    logic        halted;
    logic        tbl_valid [8];
    logic [63:0] tbl_id [8];
    logic [31:0] tbl_size [8];
    logic        tbl_vlsd [8];
    logic        tbl_sub [8];
    logic [31:0] tbl_lim [8];
    logic [31:0] tbl_cnt [8];

    assign pending = deframed_q.size();

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic halt_with(input logic [2:0] st, input logic [63:0] id,
                             output bit got, output frame_out_t r);
        halted = 1'b1;
        got = 1;
        r = '{st, 3'd0, id, 32'd0, 8'd0, 1'b0};
    endtask

    // close the record and advance the group's sample count while below its limit
    task automatic close_record();
        if (tbl_cnt[grp] < tbl_lim[grp])
            tbl_cnt[grp]++;
        phase = PH_ID;
        hdr_cnt = '0;
        len_acc = '0;
        left = '0;
    endtask

    task automatic open_body(input logic [31:0] n, output bit got,
                             output frame_out_t r);
        got = 0;
        emits = tbl_sub[grp] && (tbl_cnt[grp] < tbl_lim[grp]);
        if (n == 0)
        begin
            if (emits)
            begin
                got = 1;
                r = '{ST_EMPTY, grp, acc_id, tbl_cnt[grp], 8'd0, 1'b1};
            end
            close_record();
            acc_id = '0;
        end
        else
        begin
            left = n;
            phase = PH_BODY;
        end
    endtask

    // one stream byte through the parser
    task automatic deframe_byte(input logic [7:0] b, output bit got,
                                output frame_out_t r);
        int i;
        got = 0;
        r = '{3'd0, 3'd0, 64'd0, 32'd0, 8'd0, 1'b0};
        if (halted)
            return;
        if (consumed >= byte_limit)
        begin
            halt_with(ST_PAST_END, 64'd0, got, r);
            return;
        end
        consumed++;
        if (phase == PH_ID)
        begin
            if (!(id_width inside {4'd0, 4'd1, 4'd2, 4'd4, 4'd8}))
            begin
                halt_with(ST_BAD_WIDTH, 64'd0, got, r);
                return;
            end
            if (id_width == 0)
            begin
                // no id on the wire: slot 0 owns the record
                if (!tbl_valid[0])
                begin
                    halt_with(ST_UNKNOWN, 64'd0, got, r);
                    return;
                end
                grp = 3'd0;
                acc_id = tbl_id[0];
                if (tbl_vlsd[0])
                begin
                    phase = PH_LEN;
                    hdr_cnt = '0;
                    len_acc = '0;
                end
                else if (tbl_size[0] == 0)
                begin
                    open_body(32'd0, got, r);
                    return;
                end
                else
                    open_body(tbl_size[0], got, r);
            end
            else
            begin
                acc_id |= 64'(b) << (8 * hdr_cnt[2:0]);
                hdr_cnt++;
                if (hdr_cnt < id_width)
                    return;
                hdr_cnt = '0;
                for (i = 0; i < 8; i++)
                    if (tbl_valid[i] && tbl_id[i] == acc_id)
                        break;
                if (i >= 8)
                begin
                    halt_with(ST_UNKNOWN, acc_id, got, r);
                    return;
                end
                grp = 3'(i);
                if (tbl_vlsd[i])
                begin
                    phase = PH_LEN;
                    len_acc = '0;
                    return;
                end
                open_body(tbl_size[i], got, r);
                return;
            end
        end
        if (phase == PH_LEN)
        begin
            len_acc |= 32'(b) << (8 * hdr_cnt[1:0]);
            hdr_cnt++;
            if (hdr_cnt < 4)
                return;
            hdr_cnt = '0;
            open_body(len_acc, got, r);
            return;
        end
        // body byte
        if (emits)
        begin
            got = 1;
            r = '{ST_PAYLOAD, grp, acc_id, tbl_cnt[grp], b, left == 1};
        end
        if (left > 0)
            left--;
        if (left == 0)
        begin
            close_record();
            acc_id = '0;
        end
    endtask

    // watch transfers: results first, then the new input
    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_out_t r;
        frame_out_t e;
        bit got;
        if (!rst_n)
        begin
            id_width = '0;
            byte_limit = '0;
            phase = PH_ID;
            acc_id = '0;
            hdr_cnt = '0;
            len_acc = '0;
            left = '0;
            grp = '0;
            emits = 1'b0;
            consumed = '0;
            halted = 1'b0;
            for (int k = 0; k < 8; k++)
            begin
                tbl_valid[k] = 1'b0;
                tbl_id[k] = '0;
                tbl_size[k] = '0;
                tbl_vlsd[k] = 1'b0;
                tbl_sub[k] = 1'b0;
                tbl_lim[k] = '0;
                tbl_cnt[k] = '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ID_BYTES)
                    id_width = cfg_data[3:0];
                else
                    byte_limit = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (deframed_q.size() == 0)
                    report($sformatf("result with nothing pending, status %0d", status));
                else
                begin
                    e = deframed_q.pop_front();
                    if (status !== e.st)
                        report($sformatf("status %0d want %0d", status, e.st));
                    if (group_index !== e.grp)
                        report($sformatf("group_index %0d want %0d", group_index, e.grp));
                    if (frame_id !== e.id)
                        report($sformatf("frame_id %0h want %0h", frame_id, e.id));
                    if (sample_index !== e.smp)
                        report($sformatf("sample_index %0d want %0d", sample_index, e.smp));
                    if (payload_byte !== e.pb)
                        report($sformatf("payload_byte %0h want %0h", payload_byte, e.pb));
                    if (last_in_record !== e.last)
                        report($sformatf("last_in_record %0b want %0b", last_in_record,
                                         e.last));
                end
            end
            if (in_valid && in_ready)
            begin
                if (operation == OP_LOAD)
                begin
                    tbl_id[entry_index] = entry_record_id;
                    tbl_size[entry_index] = entry_record_bytes;
                    tbl_vlsd[entry_index] = entry_is_vlsd;
                    tbl_sub[entry_index] = entry_subscribed;
                    tbl_lim[entry_index] = entry_sample_limit;
                    tbl_valid[entry_index] = entry_valid;
                    tbl_cnt[entry_index] = '0;
                end
                else
                begin
                    deframe_byte(data_byte, got, r);
                    if (got)
                        deframed_q.insert(deframed_q.size(), r);
                end
            end
        end
    end

    initial err_count = 0;

endmodule
`default_nettype wire

[dv/tb_top.sv]
// tb_top: stimulus, clock, reset and verdict for the record deframer
// depends on mrd_pkg, measurement_record_deframer and mrd_check
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mrd_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [47:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        operation;
    logic [7:0]  data_byte;
    logic [2:0]  entry_index;
    logic [63:0] entry_record_id;
    logic [31:0] entry_record_bytes;
    logic        entry_is_vlsd;
    logic        entry_subscribed;
    logic [31:0] entry_sample_limit;
    logic        entry_valid;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [2:0]  group_index;
    logic [63:0] frame_id;
    logic [31:0] sample_index;
    logic [7:0]  payload_byte;
    logic        last_in_record;
    int          err_count;
    int          pending;

    // stimulus side view of the group table
    logic        g_valid [8];
    logic [63:0] g_id [8];
    logic [31:0] g_size [8];
    logic        g_vlsd [8];
    logic [3:0]  width;
    logic [47:0] stream_bytes;
    int          sent;
    int          stall_free;
    bit          hold_req;
    int          quiet_cycles;

    measurement_record_deframer u_dut (.*);

    mrd_check u_check (.*);

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 3000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off when asked
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (!stall_free && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // offer the prepared item and wait for its transfer
    task automatic offer();
        if (!stall_free && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
        if (sent == 150)
            hold_req = 1;
    endtask

    task automatic push_byte(input logic [7:0] b);
        operation <= OP_STREAM;
        data_byte <= b;
        stream_bytes++;
        offer();
    endtask

    task automatic load_slot(input int s, input logic [63:0] id, input logic [31:0] size,
                             input logic vlsd, input logic sub, input logic [31:0] lim,
                             input logic valid);
        operation <= OP_LOAD;
        data_byte <= 8'($urandom);
        entry_index <= 3'(s);
        entry_record_id <= id;
        entry_record_bytes <= size;
        entry_is_vlsd <= vlsd;
        entry_subscribed <= sub;
        entry_sample_limit <= lim;
        entry_valid <= valid;
        g_valid[s] = valid;
        g_id[s] = id;
        g_size[s] = size;
        g_vlsd[s] = vlsd;
        offer();
    endtask

    task automatic write_reg(input logic idx, input logic [47:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // drop valid and wait until every result has drained
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [63:0] id_mask();
        return (width >= 8) ? '1 : ((64'd1 << (8 * width)) - 1);
    endfunction

    function automatic logic [31:0] rand_limit();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'd2;
            3: return 32'hFFFF_FFFF;
            4: return $urandom;
            default: return $urandom_range(3, 8);
        endcase
    endfunction

    // random slot: usable group or garbage that is never matched
    task automatic random_slot(input int s, input bit usable);
        if (usable)
            load_slot(s, {$urandom, $urandom} & id_mask(), $urandom_range(0, 6),
                      $urandom_range(0, 1), $urandom_range(0, 3) != 0, rand_limit(), 1'b1);
        else
            load_slot(s, {$urandom, $urandom}, $urandom, $urandom_range(0, 1),
                      $urandom_range(0, 1), $urandom, 1'b0);
    endtask

    // table for a phase; the first one covers the corner groups
    task automatic fill_table(input bit corners);
        logic [63:0] dup;
        dup = {$urandom, $urandom} & id_mask();
        if (corners)
        begin
            load_slot(0, {$urandom, $urandom} & id_mask(), 3, 0, 1, 32'hFFFF_FFFF, 1);
            load_slot(1, dup, 0, 1, 1, 2, 1);
            load_slot(2, dup, 5, 0, 1, 32'hFFFF_FFFF, 1);
            load_slot(3, {$urandom, $urandom} & id_mask(), 0, 0, 1, 1, 1);
            load_slot(4, {$urandom, $urandom} & id_mask(), 2, 0, 0, 32'hFFFF_FFFF, 1);
            load_slot(5, {$urandom, $urandom} & id_mask(), 4, 0, 1, 0, 1);
            load_slot(6, '1, '1, 1, 1, '1, 0);
            load_slot(7, {$urandom, $urandom} & id_mask(), 0, 1, 1, 3, 1);
        end
        else
            for (int s = 0; s < 8; s++)
                random_slot(s, s < 4 || $urandom_range(0, 1));
    endtask

    function automatic logic [7:0] body_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // one well-formed record for a matching group, with loads mixed in
    task automatic send_record();
        int          cand[$];
        int          s;
        int          j;
        logic [31:0] n;
        logic [63:0] id;
        j = 0;
        id = '0;
        if (width != 0)
        begin
            for (int k = 0; k < 8; k++)
                if (g_valid[k] && (g_id[k] & ~id_mask()) == 0)
                    cand.insert(cand.size(), k);
            s = cand[$urandom_range(0, cand.size() - 1)];
            id = g_id[s];
            for (j = 0; j < 8; j++)
                if (g_valid[j] && g_id[j] == id)
                    break;
        end
        n = g_vlsd[j] ? 32'($urandom_range(0, 5)) : g_size[j];
        for (int k = 0; k < width; k++)
            push_byte(id[8 * k +: 8]);
        if (g_vlsd[j])
            for (int k = 0; k < 4; k++)
                push_byte(n[8 * k +: 8]);
        else if (n == 0 && width == 0)
            push_byte(body_byte());
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                random_slot($urandom_range(4, 7), $urandom_range(0, 1));
            push_byte(body_byte());
        end
    endtask

    // main sequence
    initial
    begin : stim
        logic [3:0] widths [5];
        logic [3:0] bad;
        int         goal;
        widths = '{4'd1, 4'd2, 4'd4, 4'd8, 4'd0};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = OP_STREAM;
        data_byte = '0;
        entry_index = '0;
        entry_record_id = '0;
        entry_record_bytes = '0;
        entry_is_vlsd = 1'b0;
        entry_subscribed = 1'b0;
        entry_sample_limit = '0;
        entry_valid = 1'b0;
        stream_bytes = '0;
        sent = 0;
        stall_free = 0;
        hold_req = 0;
        quiet_cycles = 0;
        for (int k = 0; k < 8; k++)
            g_valid[k] = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 7; ph++)
        begin
            width = (ph < 5) ? widths[ph] : widths[$urandom_range(0, 4)];
            if (ph == 6)
                stall_free = 1;
            settle();
            write_reg(CFG_ID_BYTES, 48'(width));
            write_reg(CFG_BYTE_LIMIT, (ph == 0 || ph == 6) ? '1 :
                      stream_bytes + 48'h1_0000_0000 + 48'($urandom));
            cfg_we <= 1'b0;
            fill_table(ph == 0);
            goal = sent + 40;
            while (sent < goal)
                send_record();
        end

        // one error per run, then the block must stay halted
        settle();
        case ($urandom_range(0, 2))
            0:
            begin
                bad = 4'($urandom_range(3, 15));
                if (bad inside {4'd4, 4'd8})
                    bad++;
                write_reg(CFG_ID_BYTES, 48'(bad));
                cfg_we <= 1'b0;
                push_byte(8'($urandom));
            end
            1:
            begin
                width = 4'd8;
                write_reg(CFG_ID_BYTES, 48'd8);
                cfg_we <= 1'b0;
                for (int s = 0; s < 8; s++)
                    random_slot(s, 0);
                for (int k = 0; k < 8; k++)
                    push_byte(8'($urandom));
            end
            default:
            begin
                write_reg(CFG_BYTE_LIMIT, stream_bytes);
                cfg_we <= 1'b0;
                push_byte(8'($urandom));
            end
        endcase
        for (int k = 0; k < 6; k++)
            push_byte(body_byte());
        random_slot(0, 1);
        push_byte(8'($urandom));
        settle();
        repeat (20) @(posedge clk);

        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

[filelist.f]
rtl/mrd_pkg.sv
rtl/mrd_slot_table.sv
rtl/measurement_record_deframer.sv
dv/mrd_check.sv
dv/tb_top.sv
